// ----- hw/rtl/q2r_pkg.sv -----
// ----------------------------------------------------------------------------
// q2r_pkg
// shared widths and types of the quaternion to rotation matrix pipeline
// ----------------------------------------------------------------------------
package q2r_pkg;

  localparam int unsigned OUT_FRAC_BITS_DEF = 14;
  localparam int unsigned NUM_ENT = 9;
  localparam int unsigned AX_W    = 16;
  localparam int unsigned SC_W    = 32;
  localparam int unsigned ENT_W   = 16;
  localparam int unsigned IN_W    = 3 * AX_W + SC_W;
  localparam int unsigned OUT_W   = NUM_ENT * ENT_W;
  localparam int unsigned NUM_W   = 67;
  localparam int unsigned MAG_W   = 65;
  localparam int unsigned REM_W   = 66;

  typedef struct packed {
    logic                           valid;
    logic                           zero;
    logic [NUM_ENT-1:0]             neg;
    logic [MAG_W-1:0]               den;
    logic [NUM_ENT-1:0][REM_W-1:0]  rem;
  } div_ctrl_t;

endpackage

// ----- hw/rtl/q2r_div_step.sv -----
// ----------------------------------------------------------------------------
// q2r_div_step
// one registered restoring division step for all nine matrix entries
// ----------------------------------------------------------------------------
module q2r_div_step #(
  parameter int unsigned QW    = 16,
  parameter bit          SHIFT = 1'b1
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   en_i,
  input  q2r_pkg::div_ctrl_t                     ctrl_i,
  input  logic [q2r_pkg::NUM_ENT-1:0][QW-1:0]    q_i,
  output q2r_pkg::div_ctrl_t                     ctrl_o,
  output logic [q2r_pkg::NUM_ENT-1:0][QW-1:0]    q_o
);
  import q2r_pkg::*;

  logic                 valid_q;
  div_ctrl_t            ctrl_d, ctrl_q;
  logic [NUM_ENT-1:0][QW-1:0] q_d, q_q;

  always_comb begin
    logic [REM_W-1:0] t;
    logic             ge;
    ctrl_d = ctrl_i;
    q_d    = q_i;
    for (int k = 0; k < NUM_ENT; k++) begin
      t  = SHIFT ? {ctrl_i.rem[k][REM_W-2:0], 1'b0} : ctrl_i.rem[k];
      ge = (t >= {1'b0, ctrl_i.den});
      ctrl_d.rem[k] = ge ? (t - {1'b0, ctrl_i.den}) : t;
      q_d[k] = {q_i[k][QW-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= ctrl_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ctrl_q <= ctrl_d;
      q_q    <= q_d;
    end
  end

  always_comb begin
    ctrl_o       = ctrl_q;
    ctrl_o.valid = valid_q;
  end
  assign q_o = q_q;

endmodule

// ----- hw/rtl/quaternion_to_rotation_matrix.sv -----
// ----------------------------------------------------------------------------
// quaternion_to_rotation_matrix
// normalizes (x,y,z,w) and emits the nine rotation matrix entries
// ----------------------------------------------------------------------------
// Accepts one quaternion per clock and delivers one matrix per clock while the
// output is not stalled. A result passes through OUT_FRAC_BITS+7 register
// stages: input register, products, sums, magnitude, then OUT_FRAC_BITS+2
// restoring division stages (one quotient bit each, nine lanes sharing the norm
// as divisor), then the rounding and output register. The whole pipeline holds
// while the output waits, so tready on the input follows the output side. An
// all-zero input gives the identity matrix; entries round to nearest, ties away
// from zero.
module quaternion_to_rotation_matrix #(
  parameter int unsigned OUT_FRAC_BITS = q2r_pkg::OUT_FRAC_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     s_axis_tvalid_i,
  output logic                     s_axis_tready_o,
  // axis_x, axis_y, axis_z, scalar_part
  input  logic [q2r_pkg::IN_W-1:0] s_axis_tdata_i,
  output logic                     m_axis_tvalid_o,
  input  logic                     m_axis_tready_i,
  // m00, m01, m02, m10, m11, m12, m20, m21, m22
  output logic [q2r_pkg::OUT_W-1:0] m_axis_tdata_o
);
  import q2r_pkg::*;

  localparam int unsigned QW = OUT_FRAC_BITS + 2;
  localparam int unsigned NS = OUT_FRAC_BITS + 2;
  localparam logic [ENT_W-1:0] ONE_SAT =
    (OUT_FRAC_BITS > 14) ? ENT_W'(32767) : ENT_W'(1 << OUT_FRAC_BITS);

  logic en;
  logic out_valid_q;
  assign en = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = en;

  // input stage
  logic                    vin_q, zin_q;
  logic signed [AX_W-1:0]  ax_q, ay_q, az_q;
  logic signed [SC_W-1:0]  w_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vin_q <= 1'b0;
    end else if (en) begin
      vin_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ax_q  <= s_axis_tdata_i[AX_W-1:0];
      ay_q  <= s_axis_tdata_i[2*AX_W-1:AX_W];
      az_q  <= s_axis_tdata_i[3*AX_W-1:2*AX_W];
      w_q   <= s_axis_tdata_i[IN_W-1:3*AX_W];
      zin_q <= (s_axis_tdata_i == '0);
    end
  end

  // product stage
  logic                          vm_q, zm_q;
  logic signed [2*AX_W-1:0]      pxx_q, pyy_q, pzz_q, pxy_q, pxz_q, pyz_q;
  logic signed [AX_W+SC_W-1:0]   pxw_q, pyw_q, pzw_q;
  logic signed [2*SC_W-1:0]      pww_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vm_q <= 1'b0;
    end else if (en) begin
      vm_q <= vin_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      zm_q  <= zin_q;
      pxx_q <= ax_q * ax_q;
      pyy_q <= ay_q * ay_q;
      pzz_q <= az_q * az_q;
      pxy_q <= ax_q * ay_q;
      pxz_q <= ax_q * az_q;
      pyz_q <= ay_q * az_q;
      pxw_q <= (AX_W+SC_W)'(ax_q) * (AX_W+SC_W)'(w_q);
      pyw_q <= (AX_W+SC_W)'(ay_q) * (AX_W+SC_W)'(w_q);
      pzw_q <= (AX_W+SC_W)'(az_q) * (AX_W+SC_W)'(w_q);
      pww_q <= (2*SC_W)'(w_q) * (2*SC_W)'(w_q);
    end
  end

  // sum stage
  logic                      vs_q, zs_q;
  logic signed [NUM_W-1:0]   n_q;
  logic signed [NUM_W-1:0]   num_q [NUM_ENT];
  logic signed [NUM_W-1:0]   xx, yy, zz, ww, xy, xz, yz, xw, yw, zw;
  logic signed [NUM_W-1:0]   n_d;
  logic signed [NUM_W-1:0]   num_d [NUM_ENT];

  always_comb begin
    xx = NUM_W'(pxx_q) <<< 32;
    yy = NUM_W'(pyy_q) <<< 32;
    zz = NUM_W'(pzz_q) <<< 32;
    xy = NUM_W'(pxy_q) <<< 32;
    xz = NUM_W'(pxz_q) <<< 32;
    yz = NUM_W'(pyz_q) <<< 32;
    xw = NUM_W'(pxw_q) <<< 16;
    yw = NUM_W'(pyw_q) <<< 16;
    zw = NUM_W'(pzw_q) <<< 16;
    ww = NUM_W'(pww_q);
    n_d      = xx + yy + zz + ww;
    num_d[0] = xx + ww - yy - zz;
    num_d[1] = (xy + zw) <<< 1;
    num_d[2] = (xz - yw) <<< 1;
    num_d[3] = (xy - zw) <<< 1;
    num_d[4] = yy + ww - xx - zz;
    num_d[5] = (yz + xw) <<< 1;
    num_d[6] = (xz + yw) <<< 1;
    num_d[7] = (yz - xw) <<< 1;
    num_d[8] = zz + ww - xx - yy;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vs_q <= 1'b0;
    end else if (en) begin
      vs_q <= vm_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      zs_q  <= zm_q;
      n_q   <= n_d;
      num_q <= num_d;
    end
  end

  // magnitude stage, feeds the divider chain
  div_ctrl_t                  ctrl_s [NS+1];
  logic [NUM_ENT-1:0][QW-1:0] q_s    [NS+1];
  div_ctrl_t                  abs_d;
  logic                       va_q;
  div_ctrl_t                  abs_q;

  always_comb begin
    logic signed [NUM_W-1:0] mag;
    abs_d       = '0;
    abs_d.valid = vs_q;
    abs_d.zero  = zs_q;
    abs_d.den   = n_q[MAG_W-1:0];
    for (int k = 0; k < NUM_ENT; k++) begin
      mag = num_q[k][NUM_W-1] ? -num_q[k] : num_q[k];
      abs_d.neg[k] = num_q[k][NUM_W-1];
      abs_d.rem[k] = {1'b0, mag[MAG_W-1:0]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else if (en) begin
      va_q <= vs_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      abs_q <= abs_d;
    end
  end

  always_comb begin
    ctrl_s[0]       = abs_q;
    ctrl_s[0].valid = va_q;
  end
  assign q_s[0] = '0;

  for (genvar s = 0; s < NS; s++) begin : g_div
    q2r_div_step #(
      .QW    (QW),
      .SHIFT (s != 0)
    ) u_step (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .ctrl_i (ctrl_s[s]),
      .q_i    (q_s[s]),
      .ctrl_o (ctrl_s[s+1]),
      .q_o    (q_s[s+1])
    );
  end

  // rounding and output register
  logic [OUT_W-1:0] out_d, out_q;

  always_comb begin
    logic [QW:0]       qp1;
    logic [32:0]       qr;
    logic [ENT_W-1:0]  ent;
    for (int k = 0; k < NUM_ENT; k++) begin
      qp1 = {1'b0, q_s[NS][k]} + (QW+1)'(1);
      qr  = 33'(qp1[QW:1]);
      if (ctrl_s[NS].neg[k]) begin
        if (qr > 33'd32768) begin
          qr = 33'd32768;
        end
        ent = ENT_W'(-qr);
      end else begin
        if (qr > 33'd32767) begin
          qr = 33'd32767;
        end
        ent = qr[ENT_W-1:0];
      end
      if (ctrl_s[NS].zero) begin
        ent = ((k == 0) || (k == 4) || (k == 8)) ? ONE_SAT : '0;
      end
      out_d[k*ENT_W +: ENT_W] = ent;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= ctrl_s[NS].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_q;

endmodule

// ----- hw/rtl/q2r_checker.sv -----
// ----------------------------------------------------------------------------
// q2r_checker
// port-level checks of the quaternion to rotation matrix block
// ----------------------------------------------------------------------------
module q2r_checker #(
  parameter int unsigned OUT_FRAC_BITS = q2r_pkg::OUT_FRAC_BITS_DEF
) (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      s_axis_tvalid_i,
  input logic                      s_axis_tready_o,
  input logic [q2r_pkg::IN_W-1:0]  s_axis_tdata_i,
  input logic                      m_axis_tvalid_o,
  input logic                      m_axis_tready_i,
  input logic [q2r_pkg::OUT_W-1:0] m_axis_tdata_o
);
  import q2r_pkg::*;

  localparam int LIM   = (OUT_FRAC_BITS > 14) ? 32767 : (1 << OUT_FRAC_BITS);
  localparam int LIM_N = (OUT_FRAC_BITS > 14) ? -32768 : -LIM;

  // output holds while stalled
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("output changed while stalled");

  // input side free whenever output can move
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o == (!m_axis_tvalid_o || m_axis_tready_i))
    else $error("tready does not follow output side");

  // the normalized entries m00 and m11 stay within one in magnitude
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |->
      ($signed(m_axis_tdata_o[15:0]) <= LIM) && ($signed(m_axis_tdata_o[15:0]) >= LIM_N) &&
      ($signed(m_axis_tdata_o[79:64]) <= LIM) && ($signed(m_axis_tdata_o[79:64]) >= LIM_N))
    else $error("matrix entry out of range");

  // no result leaves right after reset
  a_reset: assert property (@(posedge clk_i) !rst_ni |=> !m_axis_tvalid_o)
    else $error("result right after reset");

endmodule

bind quaternion_to_rotation_matrix q2r_checker #(
  .OUT_FRAC_BITS (OUT_FRAC_BITS)
) u_q2r_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tdata_i  (s_axis_tdata_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);
